### hdl/delta_command_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delta command decoder.
// ----------------------------------------------------------------------------
`ifndef DELTA_COMMAND_DECODER_ASSERT_SVH
`define DELTA_COMMAND_DECODER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define DCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dcd_pkg.sv
// ----------------------------------------------------------------------------
// dcd_pkg
// Types, opcode constants and the opcode length table of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcd_pkg;

  localparam logic [7:0] OP_UNDEF_LO = 8'h38;
  localparam logic [7:0] OP_NEAR_LO  = 8'h40;
  localparam logic [7:0] OP_RUN_LO   = 8'h60;
  localparam logic [7:0] OP_EXT      = 8'h7b;
  localparam logic [7:0] OP_LONG_LO  = 8'h80;
  localparam logic [7:0] OP_F8       = 8'hf8;
  localparam logic [7:0] OP_F9       = 8'hf9;
  localparam logic [7:0] OP_FA       = 8'hfa;
  localparam logic [7:0] OP_FB       = 8'hfb;
  localparam logic [8:0] NEAR_BIAS   = 9'h020;
  localparam logic [63:0] FAR_BIAS   = 64'h100;

  localparam int unsigned TDATA_W = 136;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_COPY   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } dcd_item_t;

  typedef struct packed {
    logic [63:0] running;
    logic [7:0]  opcode;
    logic [7:0]  format;
    logic [4:0]  count;
    logic [4:0]  expected;
    logic [63:0] len_acc;
    logic [63:0] pos_acc;
  } dcd_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] length;
    logic [63:0] source_position;
    logic [4:0]  command_bytes;
  } dcd_result_t;

  // Bytes taken by a command, judged from its first byte alone.
  function automatic logic [4:0] first_length(input logic [7:0] c);
    logic [4:0] n;
    begin
      if (c < OP_NEAR_LO)      n = 5'd1;
      else if (c < OP_RUN_LO)  n = 5'd2;
      else if (c < OP_EXT)     n = 5'd1;
      else if (c == OP_EXT)    n = 5'd3;
      else if (c < OP_LONG_LO) n = 5'(c - 8'h7a);
      else if (c < OP_F8)      n = 5'd5;
      else if (c < OP_FB)      n = 5'd3;
      else                     n = 5'(c - 8'hf6);
      return n;
    end
  endfunction

endpackage

`default_nettype wire

### hdl/dcd_in_stage.sv
// ----------------------------------------------------------------------------
// dcd_in_stage
// Input register: holds one accepted stream byte until the decode takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcd_in_stage
  import dcd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic      s_tuser,    // [0] restart
  output logic           item_valid,
  output dcd_item_t      item,
  input  wire logic      item_take
);

  assign s_tready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.data_byte <= s_tdata;
      item.restart   <= s_tuser;
    end
  end

endmodule

`default_nettype wire

### hdl/dcd_decode.sv
// ----------------------------------------------------------------------------
// dcd_decode
// One byte step: gathers fields, finishes a command and updates the running
// position. Purely combinational.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcd_decode
  import dcd_pkg::*;
(
  input  wire dcd_state_t  state,
  input  wire dcd_item_t   item,
  output dcd_state_t  state_next,
  output dcd_result_t result,
  output logic        done
);

  function automatic logic [63:0] put_byte(input logic [63:0] v, input logic [2:0] lane,
                                           input logic [7:0] b);
    logic [63:0] r;
    begin
      r = v;
      for (int j = 0; j < 8; j++) begin
        if (lane == 3'(j)) r[8*j +: 8] = r[8*j +: 8] | b;
      end
      return r;
    end
  endfunction

  dcd_state_t  cur;
  dcd_state_t  nx;
  logic [7:0]  b;
  logic [7:0]  c;
  logic [4:0]  i;
  logic [4:0]  k;
  logic [4:0]  k2;
  logic [4:0]  nsize;
  logic [4:0]  nlen;
  logic [4:0]  cnt_n;
  logic [63:0] lacc_ins;
  logic [63:0] pacc_ins;
  logic [63:0] addend;
  logic        cin;
  logic        use_base;
  logic [63:0] base;
  logic [63:0] sum_a;
  logic [63:0] sum;
  kind_t       kind;
  logic [63:0] len;
  logic [63:0] pos;

  always_comb begin
    cur = state;
    if (item.restart) begin
      cur.count   = '0;
      cur.running = '0;
    end
    b        = item.data_byte;
    nx       = cur;
    lacc_ins = cur.len_acc;
    pacc_ins = cur.pos_acc;
    i        = cur.count;
    k        = i - 5'd2;
    nsize    = {2'b0, cur.format[6:4]} + 5'd1;
    k2       = k - nsize;
    nlen     = 5'(cur.opcode - OP_FB);
    addend   = {59'b0, b[4:0]};
    cin      = 1'b0;
    use_base = 1'b0;

    if (cur.count == 5'd0) begin
      nx.opcode   = b;
      nx.format   = '0;
      nx.expected = first_length(b);
      lacc_ins    = '0;
      pacc_ins    = '0;
      use_base    = (b >= OP_NEAR_LO) && (b < OP_RUN_LO);
    end else begin
      c = cur.opcode;
      if ((c >= OP_NEAR_LO) && (c < OP_RUN_LO)) begin
        if (i == 5'd1) lacc_ins = {55'b0, {1'b0, b} + 9'd1};
      end else if (c == OP_EXT) begin
        if (i == 5'd1) begin
          nx.format   = b;
          nx.expected = 5'd3 + {2'b0, b[6:4]} + {1'b0, b[3:0]};
        end else if (k < nsize) begin
          lacc_ins = put_byte(cur.len_acc, k[2:0], b);
        end else if (k2 < 5'd8) begin
          pacc_ins = put_byte(cur.pos_acc, k2[2:0], b);
        end
      end else if ((c > OP_EXT) && (c < OP_LONG_LO)) begin
        if ((i >= 5'd1) && (i <= 5'd4)) lacc_ins = put_byte(cur.len_acc, 3'(i - 5'd1), b);
      end else if ((c >= OP_LONG_LO) && (c < OP_F8)) begin
        if ((i >= 5'd1) && (i <= 5'd4)) pacc_ins = put_byte(cur.pos_acc, 3'(i - 5'd1), b);
      end else if ((c >= OP_F8) && (c < OP_FB)) begin
        if (i == 5'd1) begin
          use_base = 1'b1;
          if (c == OP_F8) begin
            addend = {55'b0, {1'b0, b} + NEAR_BIAS};
          end else if (c == OP_F9) begin
            addend = {56'b0, b} - FAR_BIAS;
          end else if (b[0]) begin
            addend = ~{57'b0, b[7:1]};
            cin    = 1'b1;
          end else begin
            addend = {57'b0, b[7:1]};
          end
        end else if (i == 5'd2) begin
          lacc_ins = {55'b0, {1'b0, b} + 9'd1};
        end
      end else if (c >= OP_FB) begin
        if ((i >= 5'd1) && (i <= nlen)) begin
          lacc_ins = put_byte(cur.len_acc, 3'(i - 5'd1), b);
        end else if ((i > nlen) && (i <= nlen + 5'd4)) begin
          pacc_ins = put_byte(cur.pos_acc, 3'(i - 5'd1 - nlen), b);
        end
      end
    end

    // Position bases are formed a byte ahead of the command end.
    base       = cur.running + addend + {63'b0, cin};
    nx.len_acc = lacc_ins;
    nx.pos_acc = use_base ? base : pacc_ins;

    cnt_n = cur.count + 5'd1;
    done  = !(cnt_n < nx.expected);

    c    = nx.opcode;
    kind = KIND_ERROR;
    len  = '0;
    pos  = '0;
    if (c < OP_UNDEF_LO) begin
      kind = KIND_INSERT;
      len  = {56'b0, c};
    end else if (c < OP_NEAR_LO) begin
      kind = KIND_ERROR;
    end else if (c < OP_RUN_LO) begin
      kind = KIND_COPY;
      len  = lacc_ins;
      pos  = pacc_ins;
    end else if (c < OP_EXT) begin
      kind = KIND_COPY;
      len  = {56'b0, c - 8'h5f};
      pos  = cur.running;
    end else if (c == OP_EXT) begin
      if (nx.format[3:0] > 4'd8) begin
        kind = KIND_ERROR;
      end else if (nx.format[7]) begin
        kind = KIND_COPY;
        len  = lacc_ins;
        pos  = pacc_ins;
      end else begin
        kind = KIND_INSERT;
        len  = lacc_ins;
      end
    end else if (c < OP_LONG_LO) begin
      kind = KIND_INSERT;
      len  = lacc_ins;
    end else if (c < OP_F8) begin
      kind = KIND_COPY;
      len  = {57'b0, c[6:0]};
      pos  = pacc_ins;
    end else begin
      kind = KIND_COPY;
      len  = lacc_ins;
      pos  = pacc_ins;
    end

    sum_a = (kind == KIND_COPY) ? pos : cur.running;
    sum   = sum_a + len;

    if (done) begin
      nx.count    = '0;
      nx.expected = '0;
      if (kind != KIND_ERROR) nx.running = sum;
    end else begin
      nx.count = cnt_n;
    end

    state_next             = nx;
    result.kind            = kind;
    result.length          = len;
    result.source_position = pos;
    result.command_bytes   = cnt_n;
  end

endmodule

`default_nettype wire

### hdl/delta_command_decoder.sv
// ----------------------------------------------------------------------------
// delta_command_decoder
// Decodes a byte stream of delta patch commands into insert/copy results.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                         tuser
//  s_*      in   [7:0] data_byte                               [0] restart
//  m_*      out  [63:0] length, [127:64] source_position,      [1:0] kind
//                [132:128] command_bytes, [135:133] zero
//
//  One item per cycle while the decode is not held: each byte is decoded
//  between the input register and the result register, with one 64-bit add
//  on the command-end path (position bases are built one byte earlier).
//  m_tvalid rises when the result register takes the final byte's result.
//  rst is synchronous; it clears the running position and any partial command.
//  With the result register full and m_tready low the decode holds; the input
//  register still takes one more item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "delta_command_decoder_assert.svh"

module delta_command_decoder
  import dcd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [7:0]         s_tdata,  // [7:0] data_byte
  input  wire logic               s_tuser,  // [0] restart
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [TDATA_W-1:0]      m_tdata,  // length, source_position, command_bytes
  output logic [1:0]              m_tuser   // [1:0] kind
);

  logic        item_valid;
  dcd_item_t   item;
  logic        adv;
  dcd_state_t  state;
  dcd_state_t  state_next;
  dcd_result_t result;
  logic        done;
  dcd_result_t out_res;

  assign adv = item_valid && (!m_tvalid || m_tready);

  dcd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (adv)
  );

  dcd_decode u_dec (
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (result),
    .done       (done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (adv) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && done) begin
      out_res <= result;
    end
  end

  assign m_tdata = {3'b0, out_res.command_bytes, out_res.source_position, out_res.length};
  assign m_tuser = out_res.kind;

  `DCD_ASSERT_NOW(a_count_below_expected, state.count != 5'd0,
    state.count < state.expected, "partial command count past its length")
  `DCD_ASSERT_NEXT(a_done_clears_count, adv && done,
    state.count == 5'd0, "command end left a partial count")
  `DCD_ASSERT_NEXT(a_partial_keeps_count, adv && !done,
    state.count != 5'd0, "partial command lost its count")
  `DCD_ASSERT_NOW(a_error_is_empty, m_tvalid && (out_res.kind == KIND_ERROR),
    (out_res.length == 64'd0) && (out_res.source_position == 64'd0),
    "error result carries length or position")
  `DCD_ASSERT_NOW(a_insert_no_source, m_tvalid && (out_res.kind == KIND_INSERT),
    out_res.source_position == 64'd0, "insert result carries a source position")

endmodule

`default_nettype wire
